// File: rtl/core/stick_deadzone_conditioner_top_defines.svh
// Assertion macros shared by the stick deadzone conditioner
`ifndef STICK_DEADZONE_CONDITIONER_TOP_DEFINES_SVH
`define STICK_DEADZONE_CONDITIONER_TOP_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define SDC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Plain invariant checked on every clock edge outside reset
`define SDC_ASSERT_HOLD(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

`endif

// File: rtl/core/sdc_pkg.sv
// Shared codes and widths of the stick deadzone conditioner
package sdc_pkg;

  localparam int IN_W      = 16;
  localparam int OUT_W     = 16;
  localparam int REG_W     = 15;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_W     = 16;

  localparam logic [REG_W-1:0] SCALE_RST = 15'd32767;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE  = 2'd0,
    CFG_SCALE = 2'd1,
    CFG_ZONE  = 2'd2
  } cfg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE = 2'd0,
    MODE_AXIS = 2'd1,
    MODE_CIRC = 2'd2
  } zone_mode_e;

endpackage

// File: rtl/core/sdc_sqrt.sv
// Pipelined floor integer square root, one result bit per stage
module sdc_sqrt #(
  parameter int RW = 16,
  parameter int SW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [2*RW-1:0] in_rad_i,
  input  logic [SW-1:0]   in_side_i,
  output logic            out_valid_o,
  output logic [RW-1:0]   out_root_o,
  output logic [SW-1:0]   out_side_o
);

  localparam int TW = 2*RW + 1;

  logic            v_q    [RW+1];
  logic [2*RW-1:0] rem_q  [RW+1];
  logic [RW-1:0]   root_q [RW+1];
  logic [SW-1:0]   side_q [RW+1];

  // Capture the radicand
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= in_rad_i;
    root_q[0] <= '0;
    side_q[0] <= in_side_i;
  end

  // Decide one root bit per stage, most significant first
  for (genvar s = 0; s < RW; s++) begin : g_stage
    localparam int B = RW - 1 - s;
    logic [TW-1:0] trial;
    logic [TW-1:0] rem_ext;
    logic          take;

    assign trial   = (TW'(root_q[s]) << (B + 1)) | (TW'(1) << (2 * B));
    assign rem_ext = TW'(rem_q[s]);
    assign take    = rem_ext >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else begin
        v_q[s+1] <= v_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s+1]  <= take ? (2*RW)'(rem_ext - trial) : rem_q[s];
      root_q[s+1] <= take ? (root_q[s] | (RW'(1) << B)) : root_q[s];
      side_q[s+1] <= side_q[s];
    end
  end

  assign out_valid_o = v_q[RW];
  assign out_root_o  = root_q[RW];
  assign out_side_o  = side_q[RW];

endmodule

// File: rtl/core/sdc_div.sv
// Two-lane pipelined restoring divider, one quotient bit per stage
module sdc_div import sdc_pkg::*; #(
  parameter int QW = 15,
  parameter int SW = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [1:0][DIV_W+QW-1:0]    in_num_i,
  input  logic [1:0][DIV_W-1:0]       in_den_i,
  input  logic [SW-1:0]               in_side_i,
  output logic                        out_valid_o,
  output logic [1:0][QW-1:0]          out_quo_o,
  output logic [SW-1:0]               out_side_o
);

  // Numerator top part must already be below the divisor
  logic                   v_q    [QW+1];
  logic [1:0][DIV_W-1:0]  rem_q  [QW+1];
  logic [1:0][QW-1:0]     low_q  [QW+1];
  logic [1:0][DIV_W-1:0]  den_q  [QW+1];
  logic [SW-1:0]          side_q [QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= in_valid_i;
    end
  end

  // Load the request
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 2; l++) begin
      rem_q[0][l] <= in_num_i[l][QW +: DIV_W];
      low_q[0][l] <= in_num_i[l][QW-1:0];
      den_q[0][l] <= in_den_i[l];
    end
    side_q[0] <= in_side_i;
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else begin
        v_q[s+1] <= v_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[s+1] <= side_q[s];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DIV_W:0] r2;
      logic [DIV_W:0] dx;
      logic           take;

      assign r2   = {rem_q[s][l], low_q[s][l][QW-1]};
      assign dx   = {1'b0, den_q[s][l]};
      assign take = r2 >= dx;

      // Shift in the next numerator bit, subtract when it fits
      always_ff @(posedge clk_i) begin
        rem_q[s+1][l] <= take ? DIV_W'(r2 - dx) : r2[DIV_W-1:0];
        low_q[s+1][l] <= {low_q[s][l][QW-2:0], take};
        den_q[s+1][l] <= den_q[s][l];
      end
    end
  end

  assign out_valid_o = v_q[QW];
  assign out_quo_o   = low_q[QW];
  assign out_side_o  = side_q[QW];

endmodule

// File: rtl/core/stick_deadzone_conditioner_top.sv
// Stick deadzone conditioner: a new (x, y) request can start on every clock cycle and
// its result appears as a one-cycle done_o strobe with out_x_o/out_y_o; the receiver
// cannot stall it. A request passes through the square root pipeline (one root bit per
// stage), then two divider pipelines of OUT_FRAC_BITS+1 stages each, the first for
// the linear deadzone scale, the second for the radial rescale. busy_o stays low.
// Configuration writes take effect on the next cycle and must be made while idle.
`include "stick_deadzone_conditioner_top_defines.svh"

module stick_deadzone_conditioner_top import sdc_pkg::*; #(
  parameter int SAMPLE_BITS   = 16,
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [IN_W-1:0]      raw_x_i,
  input  logic [IN_W-1:0]      raw_y_i,
  output logic                 done_o,
  output logic [OUT_W-1:0]     out_x_o,
  output logic [OUT_W-1:0]     out_y_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_wdata_i
);

  localparam int SB    = SAMPLE_BITS;
  localparam int FB    = OUT_FRAC_BITS;
  localparam int QW    = FB + 1;
  localparam int NW    = DIV_W + QW;
  localparam int PW    = SB + QW;
  localparam int SQ_SW = 2 + 2*SB;
  localparam int A_SW  = 2 + 3*SB + 4;
  localparam int B_SW  = 3 + 2*OUT_W;
  localparam int LAT   = SB + 2*FB + 7;
  localparam int ONE_S = 1 << FB;
  localparam logic [QW-1:0] ONE_Q = {1'b1, {FB{1'b0}}};

  function automatic logic [OUT_W-1:0] apply_sign(input logic neg, input logic [QW-1:0] mag);
    logic signed [QW:0] sv;
    sv = $signed({1'b0, mag});
    if (neg) begin
      sv = -sv;
    end
    return OUT_W'(sv);
  endfunction

  // Configuration registers
  zone_mode_e       mode_q;
  logic [REG_W-1:0] scale_q;
  logic [REG_W-1:0] zone_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_NONE;
      scale_q <= SCALE_RST;
      zone_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:  mode_q  <= zone_mode_e'(cfg_wdata_i[MODE_W-1:0]);
        CFG_SCALE: scale_q <= cfg_wdata_i;
        CFG_ZONE:  zone_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // Stage 0: capture the request, sign taken at SAMPLE_BITS
  logic                 v0_q;
  logic signed [SB-1:0] x0_q, y0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    x0_q <= $signed(raw_x_i[SB-1:0]);
    y0_q <= $signed(raw_y_i[SB-1:0]);
  end

  // Stage 1: magnitudes and squares
  logic                   v1_q, sx1_q, sy1_q;
  logic [SB-1:0]          ax1_q, ay1_q;
  logic [2*SB-1:0]        qx1_q, qy1_q;
  logic signed [2*SB-1:0] sqx, sqy;

  assign sqx = x0_q * x0_q;
  assign sqy = y0_q * y0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sx1_q <= x0_q[SB-1];
    sy1_q <= y0_q[SB-1];
    ax1_q <= x0_q[SB-1] ? (~x0_q + SB'(1)) : x0_q;
    ay1_q <= y0_q[SB-1] ? (~y0_q + SB'(1)) : y0_q;
    qx1_q <= sqx;
    qy1_q <= sqy;
  end

  // Radial distance
  logic             sq_v;
  logic [SB-1:0]    radius;
  logic [SQ_SW-1:0] sq_side;

  sdc_sqrt #(.RW(SB), .SW(SQ_SW)) u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v1_q),
    .in_rad_i    (qx1_q + qy1_q),
    .in_side_i   ({sx1_q, sy1_q, ax1_q, ay1_q}),
    .out_valid_o (sq_v),
    .out_root_o  (radius),
    .out_side_o  (sq_side)
  );

  // Deadzone removal and saturation flags
  logic               s_sx, s_sy;
  logic [SB-1:0]      s_ax, s_ay;
  logic               is_circ, use_zone;
  logic [DIV_W-1:0]   zone_eff, va, vb, ma, mb;
  logic signed [DIV_W-1:0] den;
  logic               den_bad, in_a, in_b, sat_a, sat_b;

  assign {s_sx, s_sy, s_ax, s_ay} = sq_side;
  assign is_circ  = (mode_q == MODE_CIRC);
  assign use_zone = is_circ || (mode_q == MODE_AXIS);
  assign zone_eff = use_zone ? DIV_W'(zone_q) : '0;
  assign va       = is_circ ? DIV_W'(radius) : DIV_W'(s_ax);
  assign vb       = DIV_W'(s_ay);
  assign den      = $signed(DIV_W'(scale_q)) - $signed(zone_eff);
  assign den_bad  = den[DIV_W-1] || (den == '0);
  assign in_a     = va <= zone_eff;
  assign in_b     = vb <= zone_eff;
  assign ma       = va - zone_eff;
  assign mb       = vb - zone_eff;
  assign sat_a    = den_bad || (ma >= DIV_W'(den));
  assign sat_b    = den_bad || (mb >= DIV_W'(den));

  logic                a_v;
  logic [1:0][QW-1:0]  a_quo;
  logic [A_SW-1:0]     a_side;

  sdc_div #(.QW(QW), .SW(A_SW)) u_div_zone (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sq_v),
    .in_num_i    ({NW'(mb) << FB, NW'(ma) << FB}),
    .in_den_i    ({DIV_W'(den), DIV_W'(den)}),
    .in_side_i   ({s_sx, s_sy, s_ax, s_ay, radius, in_a, in_b, sat_a, sat_b}),
    .out_valid_o (a_v),
    .out_quo_o   (a_quo),
    .out_side_o  (a_side)
  );

  // Clamp the scaled values, form axis results and radial products
  logic              z_sx, z_sy, z_in_a, z_in_b, z_sat_a, z_sat_b;
  logic [SB-1:0]     z_ax, z_ay, z_dist;
  logic [QW-1:0]     qa, qb;
  logic [OUT_W-1:0]  rx, ry;
  logic              rad_ok;
  logic [PW-1:0]     px, py;

  assign {z_sx, z_sy, z_ax, z_ay, z_dist, z_in_a, z_in_b, z_sat_a, z_sat_b} = a_side;
  assign qa     = z_in_a ? '0 : (z_sat_a ? ONE_Q : a_quo[0]);
  assign qb     = z_in_b ? '0 : (z_sat_b ? ONE_Q : a_quo[1]);
  assign rx     = apply_sign(z_sx, qa);
  assign ry     = apply_sign(z_sy, qb);
  assign rad_ok = (qa != '0) && (z_dist != '0);
  assign px     = z_ax * qa;
  assign py     = z_ay * qa;

  logic                b_v;
  logic [1:0][QW-1:0]  b_quo;
  logic [B_SW-1:0]     b_side;

  sdc_div #(.QW(QW), .SW(B_SW)) u_div_radial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (a_v),
    .in_num_i    ({NW'(py), NW'(px)}),
    .in_den_i    ({DIV_W'(z_dist), DIV_W'(z_dist)}),
    .in_side_i   ({z_sx, z_sy, rad_ok, rx, ry}),
    .out_valid_o (b_v),
    .out_quo_o   (b_quo),
    .out_side_o  (b_side)
  );

  // Select the result and drive the output strobe
  logic             f_sx, f_sy, f_ok;
  logic [OUT_W-1:0] f_rx, f_ry;
  logic             done_q;
  logic [OUT_W-1:0] out_x_q, out_y_q;

  assign {f_sx, f_sy, f_ok, f_rx, f_ry} = b_side;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= b_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_circ) begin
      out_x_q <= f_ok ? apply_sign(f_sx, b_quo[0]) : '0;
      out_y_q <= f_ok ? apply_sign(f_sy, b_quo[1]) : '0;
    end else begin
      out_x_q <= f_rx;
      out_y_q <= f_ry;
    end
  end

  assign done_o  = done_q;
  assign out_x_o = out_x_q;
  assign out_y_o = out_y_q;

  // Checks
  logic x_in_range, y_in_range;

  assign x_in_range = ($signed(out_x_o) <= ONE_S) && ($signed(out_x_o) >= -ONE_S);
  assign y_in_range = ($signed(out_y_o) <= ONE_S) && ($signed(out_y_o) >= -ONE_S);

  `SDC_ASSERT_IMPLY(a_done_latency, done_o, $past(start_i && !busy_o, LAT + 1), "result without request")
  `SDC_ASSERT_HOLD(a_out_x_range, !done_o || (FB > 14) || x_in_range, "out_x beyond one")
  `SDC_ASSERT_HOLD(a_out_y_range, !done_o || (FB > 14) || y_in_range, "out_y beyond one")

endmodule

// File: tb/tb_stick_deadzone_conditioner_top.sv
// Self-checking testbench for the stick deadzone conditioner top level
module tb_stick_deadzone_conditioner_top;
  import sdc_pkg::*;

  localparam int ONE       = 16384;
  localparam int LAT       = 51;
  localparam int WDOG_MAX  = 20000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  logic [IN_W-1:0]      raw_x_i;
  logic [IN_W-1:0]      raw_y_i;
  logic                 done_o;
  logic [OUT_W-1:0]     out_x_o;
  logic [OUT_W-1:0]     out_y_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [REG_W-1:0]     cfg_wdata_i;

  // Shadow copy of the block configuration
  logic [MODE_W-1:0] mdl_mode;
  logic [REG_W-1:0]  mdl_scale;
  logic [REG_W-1:0]  mdl_zone;

  logic [OUT_W-1:0] pend_x_q[$];
  logic [OUT_W-1:0] pend_y_q[$];

  int err_cnt;
  int sent_cnt;
  int seen_cnt;
  int wdog_cnt;
  int idle_pct;

  stick_deadzone_conditioner_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .raw_x_i     (raw_x_i),
    .raw_y_i     (raw_y_i),
    .done_o      (done_o),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Move a value toward zero by the zone, then scale to Q2.14 and saturate
  function automatic longint apply_zone(longint v, longint scale, longint zone);
    longint denom;
    longint q;
    if (v < -zone) v = v + zone;
    else if (v > zone) v = v - zone;
    else return 0;
    denom = scale - zone;
    if (denom <= 0) return (v > 0) ? ONE : -ONE;
    q = (v * ONE) / denom;
    if (q > ONE) q = ONE;
    if (q < -ONE) q = -ONE;
    return q;
  endfunction

  function automatic longint floor_sqrt(longint n);
    longint root;
    longint lsb;
    root = 0;
    lsb = longint'(1) << 62;
    while (lsb > n) lsb = lsb >> 2;
    while (lsb != 0) begin
      if (n >= root + lsb) begin
        n = n - (root + lsb);
        root = (root >> 1) + lsb;
      end else begin
        root = root >> 1;
      end
      lsb = lsb >> 2;
    end
    return root;
  endfunction

  function automatic longint sat_one(longint v);
    if (v > ONE) return ONE;
    if (v < -ONE) return -ONE;
    return v;
  endfunction

  // Compute the conditioned pair for one request
  task automatic condition_pair(input logic [IN_W-1:0] rx, input logic [IN_W-1:0] ry,
                                output logic [OUT_W-1:0] cx, output logic [OUT_W-1:0] cy);
    longint x;
    longint y;
    longint radius;
    longint wanted;
    longint ox;
    longint oy;
    x = longint'($signed(rx));
    y = longint'($signed(ry));
    if (mdl_mode == MODE_AXIS) begin
      ox = apply_zone(x, mdl_scale, mdl_zone);
      oy = apply_zone(y, mdl_scale, mdl_zone);
    end else if (mdl_mode == MODE_CIRC) begin
      radius = floor_sqrt(x * x + y * y);
      wanted = apply_zone(radius, mdl_scale, mdl_zone);
      if (wanted > 0 && radius > 0) begin
        ox = sat_one((x * wanted) / radius);
        oy = sat_one((y * wanted) / radius);
      end else begin
        ox = 0;
        oy = 0;
      end
    end else begin
      ox = apply_zone(x, mdl_scale, 0);
      oy = apply_zone(y, mdl_scale, 0);
    end
    cx = ox[OUT_W-1:0];
    cy = oy[OUT_W-1:0];
  endtask

  // Check each result against the oldest expected pair
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      seen_cnt++;
      if (pend_x_q.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d", $time,
                 $signed(out_x_o), $signed(out_y_o));
        err_cnt++;
      end else begin
        if (out_x_o !== pend_x_q[0]) begin
          $display("%0t: out_x expected %0d actual %0d", $time,
                   $signed(pend_x_q[0]), $signed(out_x_o));
          err_cnt++;
        end
        if (out_y_o !== pend_y_q[0]) begin
          $display("%0t: out_y expected %0d actual %0d", $time,
                   $signed(pend_y_q[0]), $signed(out_y_o));
          err_cnt++;
        end
        void'(pend_x_q.pop_front());
        void'(pend_y_q.pop_front());
      end
    end
  end

  // Watchdog: end the run when nothing is accepted for too long
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || cfg_we_i) wdog_cnt <= 0;
    else wdog_cnt <= wdog_cnt + 1;
    if (wdog_cnt >= WDOG_MAX) begin
      $display("%0t: watchdog timeout", $time);
      $display("tb_stick_deadzone_conditioner_top: done, errors");
      $finish;
    end
  end

  // Send one request, with a random sender gap first
  task automatic send_pair(input logic [IN_W-1:0] rx, input logic [IN_W-1:0] ry);
    logic [OUT_W-1:0] cx;
    logic [OUT_W-1:0] cy;
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    raw_x_i <= rx;
    raw_y_i <= ry;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    condition_pair(rx, ry, cx, cy);
    pend_x_q.push_back(cx);
    pend_y_q.push_back(cy);
    sent_cnt++;
  endtask

  // Drain the pipeline, then write all three registers
  task automatic set_config(input logic [MODE_W-1:0] mode, input logic [REG_W-1:0] scale,
                            input logic [REG_W-1:0] zone);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pend_x_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_MODE;
    cfg_wdata_i <= REG_W'(mode);
    @(posedge clk_i);
    cfg_idx_i <= CFG_SCALE;
    cfg_wdata_i <= scale;
    @(posedge clk_i);
    cfg_idx_i <= CFG_ZONE;
    cfg_wdata_i <= zone;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    mdl_mode = mode;
    mdl_scale = scale;
    mdl_zone = zone;
  endtask

  function automatic logic [IN_W-1:0] rand_sample();
    case ($urandom_range(3))
      0: return IN_W'($urandom);
      1: return IN_W'($urandom_range(64)) - 16'd32;
      2: return $urandom_range(1) ? 16'h8000 + IN_W'($urandom_range(40)) :
                                    16'h7FFF - IN_W'($urandom_range(40));
      default: return IN_W'($signed(int'(mdl_zone)) + $signed($urandom_range(20)) - 10);
    endcase
  endfunction

  // Edge and corner samples in every mode, including the reserved mode
  task automatic test_directed();
    logic [IN_W-1:0] pts[12];
    logic [MODE_W-1:0] m;
    pts = '{16'h0000, 16'h7FFF, 16'h8000, 16'h8001, 16'h0001, 16'hFFFF,
            16'd1000, 16'hFC18, 16'd999, 16'd1001, 16'h5A82, 16'hA57E};
    idle_pct = 0;
    for (int k = 0; k < 6; k++) send_pair(pts[k], pts[5-k]);
    for (int mi = 0; mi < 4; mi++) begin
      m = MODE_W'(mi);
      set_config(m, 15'd20000, 15'd1000);
      for (int k = 0; k < 5; k++) send_pair(pts[$urandom_range(11)], pts[$urandom_range(11)]);
    end
    // scale not above zone, and the smallest scale
    set_config(MODE_AXIS, 15'd1000, 15'd1000);
    send_pair(16'd999, 16'hFC17);
    send_pair(16'd1001, 16'h0000);
    set_config(MODE_CIRC, 15'd0, 15'd0);
    send_pair(16'd3, 16'hFFFC);
    send_pair(16'd0, 16'd0);
    set_config(MODE_NONE, 15'd1, 15'h7FFF);
    send_pair(16'd1, 16'hFFFF);
  endtask

  // Random requests over several settings and idling phases
  task automatic test_random();
    logic [REG_W-1:0] scale;
    logic [REG_W-1:0] zone;
    int pcts[4];
    pcts = '{0, 70, 0, 23};
    for (int ph = 0; ph < 20; ph++) begin
      idle_pct = pcts[ph % 4];
      case (ph % 5)
        0: begin scale = 15'h7FFF; zone = 15'd0; end
        1: begin scale = 15'h7FFF; zone = 15'h7FFF; end
        2: begin scale = 15'd1; zone = 15'd0; end
        default: begin scale = REG_W'($urandom); zone = REG_W'($urandom_range(8000)); end
      endcase
      set_config(MODE_W'($urandom_range(3)), scale, zone);
      for (int k = 0; k < 100; k++) send_pair(rand_sample(), rand_sample());
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    raw_x_i = '0;
    raw_y_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_MODE;
    cfg_wdata_i = '0;
    err_cnt = 0;
    sent_cnt = 0;
    seen_cnt = 0;
    wdog_cnt = 0;
    idle_pct = 0;
    mdl_mode = MODE_NONE;
    mdl_scale = SCALE_RST;
    mdl_zone = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    start_i <= 1'b0;
    while (pend_x_q.size() != 0) @(posedge clk_i);
    repeat (LAT + 10) @(posedge clk_i);
    $display("Sent %0d stick pairs over all zone modes, extreme scales and zones,", sent_cnt);
    $display("with and without sender gaps; %0d results checked.", seen_cnt);
    if (err_cnt == 0 && pend_x_q.size() == 0) begin
      $display("tb_stick_deadzone_conditioner_top: done, clean");
    end else begin
      $display("tb_stick_deadzone_conditioner_top: done, errors");
    end
    $finish;
  end

endmodule
